[hdl/mlb_pkg.sv]
package mlb_pkg;

   localparam int NumCoresDefault = 8;
   localparam int CountWidthDefault = 16;

   localparam logic [3:0]  CoreCountReset = 4'd8;
   localparam logic [63:0] PeriodReset = 64'd5000000;

   // operation codes
   localparam logic [1:0] OP_SCHEDULE   = 2'd0;
   localparam logic [1:0] OP_UNSCHEDULE = 2'd1;
   localparam logic [1:0] OP_SELECT     = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_PLACED    = 2'd0;
   localparam logic [1:0] KIND_MIGRATION = 2'd1;
   localparam logic [1:0] KIND_DEDICATED = 2'd2;
   localparam logic [1:0] KIND_DELEGATE  = 2'd3;

   // register indexes
   localparam logic [0:0] REG_CORE_COUNT = 1'd0;
   localparam logic [0:0] REG_PERIOD     = 1'd1;

   // command broadcast along the cell row
   localparam logic [2:0] CMD_NONE     = 3'd0;
   localparam logic [2:0] CMD_INC      = 3'd1;
   localparam logic [2:0] CMD_DEDICATE = 3'd2;
   localparam logic [2:0] CMD_UNSCHED  = 3'd3;
   localparam logic [2:0] CMD_TOUCH    = 3'd4;
   localparam logic [2:0] CMD_ADD      = 3'd5;
   localparam logic [2:0] CMD_SUB      = 3'd6;

endpackage

[hdl/mlb_cell.sv]
// one core: holds count, pid and touched flag; passes scan results along the row
module mlb_cell
   import mlb_pkg::*;
#(
   parameter int IDX_W = 3,
   parameter int CNT_W = 16,
   parameter logic [IDX_W-1:0] MY_IDX = '0,
   parameter bit TOUCH_RESET = 1'b0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             active,
   // command
   input  logic [2:0]       cmd,
   input  logic [IDX_W-1:0] cmd_core,
   input  logic [31:0]      cmd_pid,
   input  logic [CNT_W-1:0] cmd_amount,
   // scan chain in
   input  logic             lo_found_i,
   input  logic [CNT_W-1:0] lo_val_i,
   input  logic [IDX_W-1:0] lo_idx_i,
   input  logic [CNT_W-1:0] hi_val_i,
   input  logic [IDX_W-1:0] hi_idx_i,
   input  logic             un_found_i,
   input  logic [IDX_W-1:0] un_idx_i,
   // scan chain out
   output logic             lo_found_o,
   output logic [CNT_W-1:0] lo_val_o,
   output logic [IDX_W-1:0] lo_idx_o,
   output logic [CNT_W-1:0] hi_val_o,
   output logic [IDX_W-1:0] hi_idx_o,
   output logic             un_found_o,
   output logic [IDX_W-1:0] un_idx_o,
   // own view
   output logic [CNT_W-1:0] count_o,
   output logic [31:0]      pid_o
);

   localparam logic [CNT_W-1:0] CntMax = '1;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      pid_ff, pid_in;
   logic             touched_ff, touched_in;
   logic             hit;

   assign hit = (cmd_core == MY_IDX);
   assign count_o = count_ff;
   assign pid_o = pid_ff;

   // state update
   always_comb begin
      count_in = count_ff;
      pid_in = pid_ff;
      touched_in = touched_ff;
      if (hit) begin
         case (cmd)
            CMD_INC: begin
               touched_in = 1'b1;
               if (count_ff != CntMax) count_in = count_ff + 1'b1;
            end
            CMD_DEDICATE: begin
               pid_in = cmd_pid;
               count_in = CntMax;
            end
            CMD_UNSCHED: begin
               if (pid_ff != 32'd0) begin
                  pid_in = '0;
                  count_in = '0;
               end else begin
                  touched_in = 1'b1;
                  if (count_ff != '0) count_in = count_ff - 1'b1;
               end
            end
            CMD_TOUCH: touched_in = 1'b1;
            CMD_ADD: begin
               touched_in = 1'b1;
               count_in = count_ff + cmd_amount;
            end
            CMD_SUB: count_in = count_ff - cmd_amount;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pid_ff <= '0;
         touched_ff <= TOUCH_RESET;
      end else begin
         count_ff <= count_in;
         pid_ff <= pid_in;
         touched_ff <= touched_in;
      end
   end

   // least: first smallest; most: first largest non-dedicated; first untouched above 0
   always_comb begin
      lo_found_o = lo_found_i;
      lo_val_o = lo_val_i;
      lo_idx_o = lo_idx_i;
      if (active && (!lo_found_i || count_ff < lo_val_i)) begin
         lo_found_o = 1'b1;
         lo_val_o = count_ff;
         lo_idx_o = MY_IDX;
      end
      hi_val_o = hi_val_i;
      hi_idx_o = hi_idx_i;
      if (active && pid_ff == 32'd0 && count_ff > hi_val_i) begin
         hi_val_o = count_ff;
         hi_idx_o = MY_IDX;
      end
      un_found_o = un_found_i;
      un_idx_o = un_idx_i;
      if (active && !un_found_i && !touched_ff && MY_IDX != '0) begin
         un_found_o = 1'b1;
         un_idx_o = MY_IDX;
      end
   end

endmodule

[hdl/mlb_row.sv]
// row of cells with registered scan results at the end of the chain
module mlb_row
   import mlb_pkg::*;
#(
   parameter int NUM_CORES = NumCoresDefault,
   parameter int COUNT_WIDTH = CountWidthDefault,
   parameter int IDX_W = $clog2(NUM_CORES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [IDX_W:0]         n_active,
   input  logic [2:0]             cmd,
   input  logic [IDX_W-1:0]       cmd_core,
   input  logic [31:0]            cmd_pid,
   input  logic [COUNT_WIDTH-1:0] cmd_amount,
   input  logic [IDX_W-1:0]       sel_core,
   output logic [IDX_W-1:0]       lo_idx_ff,
   output logic [COUNT_WIDTH-1:0] lo_val_ff,
   output logic [IDX_W-1:0]       hi_idx_ff,
   output logic [COUNT_WIDTH-1:0] hi_val_ff,
   output logic                   un_found_ff,
   output logic [IDX_W-1:0]       un_idx_ff,
   output logic [COUNT_WIDTH-1:0] sel_count,
   output logic [31:0]            sel_pid
);

   logic                   lo_f [NUM_CORES+1];
   logic [COUNT_WIDTH-1:0] lo_v [NUM_CORES+1];
   logic [IDX_W-1:0]       lo_i [NUM_CORES+1];
   logic [COUNT_WIDTH-1:0] hi_v [NUM_CORES+1];
   logic [IDX_W-1:0]       hi_i [NUM_CORES+1];
   logic                   un_f [NUM_CORES+1];
   logic [IDX_W-1:0]       un_i [NUM_CORES+1];
   logic [COUNT_WIDTH-1:0] cnt  [NUM_CORES];
   logic [31:0]            pid  [NUM_CORES];

   assign lo_f[0] = 1'b0;
   assign lo_v[0] = '0;
   assign lo_i[0] = '0;
   assign hi_v[0] = '0;
   assign hi_i[0] = '0;
   assign un_f[0] = 1'b0;
   assign un_i[0] = '0;

   for (genvar g = 0; g < NUM_CORES; g++) begin : g_cell
      mlb_cell #(
         .IDX_W(IDX_W), .CNT_W(COUNT_WIDTH),
         .MY_IDX(IDX_W'(g)), .TOUCH_RESET(g == 0)
      ) u_cell (
         .clock, .reset,
         .active((IDX_W+1)'(g) < n_active),
         .cmd, .cmd_core, .cmd_pid, .cmd_amount,
         .lo_found_i(lo_f[g]), .lo_val_i(lo_v[g]), .lo_idx_i(lo_i[g]),
         .hi_val_i(hi_v[g]), .hi_idx_i(hi_i[g]),
         .un_found_i(un_f[g]), .un_idx_i(un_i[g]),
         .lo_found_o(lo_f[g+1]), .lo_val_o(lo_v[g+1]), .lo_idx_o(lo_i[g+1]),
         .hi_val_o(hi_v[g+1]), .hi_idx_o(hi_i[g+1]),
         .un_found_o(un_f[g+1]), .un_idx_o(un_i[g+1]),
         .count_o(cnt[g]), .pid_o(pid[g])
      );
   end

   assign sel_count = cnt[sel_core];
   assign sel_pid = pid[sel_core];

   // scan results registered once per cycle
   always_ff @(posedge clock) begin
      lo_idx_ff <= lo_i[NUM_CORES];
      lo_val_ff <= lo_v[NUM_CORES];
      hi_idx_ff <= (hi_v[NUM_CORES] == '0) ? '0 : hi_i[NUM_CORES];
      hi_val_ff <= hi_v[NUM_CORES];
      un_found_ff <= un_f[NUM_CORES];
      un_idx_ff <= un_i[NUM_CORES];
   end

endmodule

[hdl/multicore_load_balancer_top.sv]
// multicore load balancer
// input channel: req_* fields are taken at a clock edge with start high and busy low.
// operation schedule places a job and gives one placed item; unschedule gives no item;
// select gives up to two migration items and then a dedicated or delegate item.
// result channel: each item is on rsp_* for one cycle marked by rsp_valid; rsp_last
// flags the final item of a request. the receiver cannot hold items off.
// throughput is one request at a time; busy drops in the cycle that shows the last
// item, so the next request can be taken at the end of that cycle. a rebalance shift
// first lets the registered scan along the row of per-core cells settle, then does
// the subtract on the source, then the add on the destination.
// configuration: csr_* apb port, core_count at 0x0, rebalance_period at 0x8; these are
// to be written only while idle, which the block itself does not enforce. reset clears
// counts and pids, touches core 0, loads register defaults; no clearing pass is needed.
module multicore_load_balancer_top
   import mlb_pkg::*;
#(
   parameter int NUM_CORES = NumCoresDefault,
   parameter int COUNT_WIDTH = CountWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_job_pid,
   input  logic        req_titanic,
   input  logic [2:0]  req_core_index,
   input  logic [63:0] req_now_time,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_core_out,
   output logic [2:0]  rsp_source_core,
   output logic [15:0] rsp_move_count,
   output logic [31:0] rsp_selected_pid,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = $clog2(NUM_CORES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;

   // configuration registers
   logic [3:0]  core_count_ff;
   logic [63:0] period_ff;
   logic        csr_wr;
   logic [0:0]  csr_reg;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_reg = csr_paddr[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         core_count_ff <= CoreCountReset;
         period_ff <= PeriodReset;
      end else if (csr_wr && csr_paddr[2:0] == 3'd0) begin
         if (csr_reg == REG_CORE_COUNT) core_count_ff <= csr_pwdata[3:0];
         else period_ff <= csr_pwdata;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2:0] == 3'd0) begin
         if (csr_reg == REG_CORE_COUNT) csr_prdata = {60'd0, core_count_ff};
         else csr_prdata = period_ff;
      end
   end

   // effective core count
   logic [IDX_W:0] n_act;
   always_comb begin
      if (core_count_ff == 4'd0) n_act = (IDX_W+1)'(1);
      else if (32'(core_count_ff) > NUM_CORES) n_act = (IDX_W+1)'(NUM_CORES);
      else n_act = (IDX_W+1)'(core_count_ff);
   end

   // request registers
   logic [2:0]  state_ff, state_in;
   logic [1:0]  op_ff;
   logic [31:0] pid_ff;
   logic        tit_ff;
   logic [2:0]  core_ff;
   logic [1:0]  shift_ff, shift_in;
   logic [1:0]  cool_ff, cool_in;
   logic [IDX_W-1:0] cache_ff, cache_in;
   logic [63:0] last_rb_ff, last_rb_in;

   // row control
   logic [2:0]             cmd;
   logic [IDX_W-1:0]       cmd_core;
   logic [COUNT_WIDTH-1:0] cmd_amount;
   logic [IDX_W-1:0]       sel_core;
   logic [IDX_W-1:0]       lo_idx, hi_idx, un_idx;
   logic [COUNT_WIDTH-1:0] lo_val, hi_val, sel_count;
   logic                   un_found;
   logic [31:0]            sel_pid;

   // the add half of a shift happens the cycle after the subtract
   logic             add_pend_ff;
   logic [IDX_W-1:0] add_core_ff;
   logic [COUNT_WIDTH-1:0] add_amt_ff;
   logic [1:0]       shifts_ff;
   logic [2:0]       cmd_fin;
   logic [IDX_W-1:0] core_fin;
   logic [COUNT_WIDTH-1:0] amt_fin;

   mlb_row #(.NUM_CORES(NUM_CORES), .COUNT_WIDTH(COUNT_WIDTH), .IDX_W(IDX_W)) u_row (
      .clock, .reset, .n_active(n_act),
      .cmd(cmd_fin), .cmd_core(core_fin), .cmd_pid(pid_ff), .cmd_amount(amt_fin),
      .sel_core,
      .lo_idx_ff(lo_idx), .lo_val_ff(lo_val), .hi_idx_ff(hi_idx), .hi_val_ff(hi_val),
      .un_found_ff(un_found), .un_idx_ff(un_idx),
      .sel_count, .sel_pid
   );

   logic core_ok;
   assign core_ok = {1'b0, core_ff} < 4'(n_act);
   assign busy = (state_ff != S_IDLE);

   // selected core for the pid read, cached core for the least count read
   assign sel_core = (state_ff == S_FINAL) ? core_ff[IDX_W-1:0] : cache_ff;

   // rebalance test, done at acceptance
   logic        rb_go;
   logic [63:0] diff_t;
   assign diff_t = req_now_time - last_rb_ff;
   assign rb_go = (n_act > (IDX_W+1)'(1)) && (req_now_time > last_rb_ff)
                  && (diff_t > period_ff);

   // least pick with cache
   logic             use_cache;
   logic [IDX_W-1:0] least;
   assign use_cache = (cool_ff != 2'd0) && ({1'b0, cache_ff} < n_act);
   assign least = use_cache ? cache_ff : lo_idx;

   // shift amount; least count read by index
   logic [COUNT_WIDTH-1:0] least_count, dsub, moves;
   logic                   do_move;
   assign least_count = use_cache ? sel_count : lo_val;
   assign do_move = hi_val > least_count;
   assign dsub = hi_val - least_count;
   assign moves = (dsub >> 1) + COUNT_WIDTH'(dsub[0]);

   logic        out_v;
   logic [1:0]  out_kind;
   logic [2:0]  out_core, out_src;
   logic [15:0] out_moves;
   logic [31:0] out_pid;
   logic        out_last;

   always_comb begin
      state_in = state_ff;
      shift_in = shift_ff;
      cool_in = cool_ff;
      cache_in = cache_ff;
      last_rb_in = last_rb_ff;
      cmd = CMD_NONE;
      cmd_core = core_ff[IDX_W-1:0];
      cmd_amount = '0;
      out_v = 1'b0;
      out_kind = KIND_PLACED;
      out_core = '0;
      out_src = '0;
      out_moves = '0;
      out_pid = '0;
      out_last = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN;
               shift_in = 2'd0;
               if (req_operation == OP_SELECT && rb_go) begin
                  last_rb_in = req_now_time;
                  state_in = S_SHIFT;
               end else if (req_operation == OP_SELECT) state_in = S_FINAL;
               else if (req_operation != OP_SCHEDULE && req_operation != OP_UNSCHEDULE)
                  state_in = S_IDLE;
            end
         end
         S_SCAN: state_in = S_EXEC;
         S_EXEC: begin
            state_in = S_IDLE;
            out_last = 1'b1;
            if (op_ff == OP_SCHEDULE) begin
               out_v = 1'b1;
               if (tit_ff && un_found) begin
                  cmd = CMD_DEDICATE;
                  cmd_core = un_idx;
                  out_core = 3'(un_idx);
               end else begin
                  cmd = CMD_INC;
                  cmd_core = least;
                  out_core = 3'(least);
                  if (use_cache) cool_in = cool_ff - 2'd1;
                  else begin
                     cache_in = lo_idx;
                     cool_in = 2'd2;
                  end
               end
            end else if (core_ok) begin
               cmd = CMD_UNSCHED;
            end
         end
         S_SHIFT: begin
            // scan settles, then the subtract with its item, then the add
            shift_in = shift_ff + 2'd1;
            if (shift_ff == 2'd1) begin
               out_v = 1'b1;
               out_kind = KIND_MIGRATION;
               out_core = 3'(least);
               out_src = 3'(hi_idx);
               if (do_move) begin
                  out_moves = (COUNT_WIDTH > 16 && moves > COUNT_WIDTH'(16'hFFFF))
                              ? 16'hFFFF : 16'(moves);
                  cmd = CMD_SUB;
                  cmd_core = hi_idx;
                  cmd_amount = moves;
               end
               if (use_cache) cool_in = cool_ff - 2'd1;
               else begin
                  cache_in = lo_idx;
                  cool_in = 2'd2;
               end
            end else if (shift_ff == 2'd2) begin
               shift_in = 2'd0;
               if (shifts_ff == 2'd2) state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            out_v = 1'b1;
            out_last = 1'b1;
            out_core = core_ff;
            state_in = S_IDLE;
            cmd_core = core_ff[IDX_W-1:0];
            if (core_ok && sel_pid != 32'd0) begin
               out_kind = KIND_DEDICATED;
               out_pid = sel_pid;
            end else begin
               out_kind = KIND_DELEGATE;
               if (core_ok) cmd = CMD_TOUCH;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // the row sees the pending add in place of the current command
   always_comb begin
      cmd_fin = cmd;
      core_fin = cmd_core;
      amt_fin = cmd_amount;
      if (add_pend_ff) begin
         cmd_fin = CMD_ADD;
         core_fin = add_core_ff;
         amt_fin = add_amt_ff;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         shift_ff <= '0;
         cool_ff <= '0;
         cache_ff <= '0;
         last_rb_ff <= '0;
         add_pend_ff <= 1'b0;
         shifts_ff <= '0;
      end else begin
         state_ff <= state_in;
         shift_ff <= shift_in;
         cool_ff <= cool_in;
         cache_ff <= cache_in;
         last_rb_ff <= last_rb_in;
         add_pend_ff <= (state_ff == S_SHIFT) && (shift_ff == 2'd1) && do_move;
         if (state_ff == S_IDLE) shifts_ff <= '0;
         else if (state_ff == S_SHIFT && shift_ff == 2'd1) shifts_ff <= shifts_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      add_core_ff <= least;
      add_amt_ff <= moves;
      if (state_ff == S_IDLE && start) begin
         op_ff <= req_operation;
         pid_ff <= req_job_pid;
         tit_ff <= req_titanic;
         core_ff <= req_core_index;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= out_v;
      rsp_kind <= out_kind;
      rsp_core_out <= out_core;
      rsp_source_core <= out_src;
      rsp_move_count <= out_moves;
      rsp_selected_pid <= out_pid;
      rsp_last <= out_last;
   end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import mlb_pkg::*;

   localparam int NCORES = 8;
   localparam logic [15:0] CNT_FULL = 16'hFFFF;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  core_out;
      logic [2:0]  source_core;
      logic [15:0] move_count;
      logic [31:0] selected_pid;
      logic        last;
   } balance_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]  req_operation = '0;
   logic [31:0] req_job_pid = '0;
   logic        req_titanic = 1'b0;
   logic [2:0]  req_core_index = '0;
   logic [63:0] req_now_time = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_core_out;
   logic [2:0]  rsp_source_core;
   logic [15:0] rsp_move_count;
   logic [31:0] rsp_selected_pid;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   multicore_load_balancer_top dut (.*);

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow state of the balancer
   logic [3:0]  sh_core_count;
   logic [63:0] sh_period;
   logic [15:0] sh_jobs [NCORES];
   logic [31:0] sh_pid [NCORES];
   logic        sh_touched [NCORES];
   logic [2:0]  sh_cached;
   logic [1:0]  sh_cooldown;
   logic [63:0] sh_last_pass;

   balance_result_type expected_results[$];
   int errors = 0;
   int results_seen = 0;
   int migrations_seen = 0;
   int items_sent = 0;
   int send_gap_pct = 0;
   longint cycles = 0;

   function automatic int cores_in_use();
      if (sh_core_count == 0) return 1;
      if (sh_core_count > NCORES) return NCORES;
      return int'(sh_core_count);
   endfunction

   function automatic void shadow_reset();
      sh_core_count = CoreCountReset;
      sh_period = PeriodReset;
      for (int i = 0; i < NCORES; i++) begin
         sh_jobs[i] = '0;
         sh_pid[i] = '0;
         sh_touched[i] = 1'b0;
      end
      sh_touched[0] = 1'b1;
      sh_cached = '0;
      sh_cooldown = '0;
      sh_last_pass = '0;
   endfunction

   function automatic logic [2:0] least_loaded_core();
      int n;
      int best;
      logic [16:0] bestv;
      n = cores_in_use();
      best = 0;
      bestv = 17'h1FFFF;
      if (sh_cooldown > 0 && sh_cached < n) begin
         sh_cooldown--;
         return sh_cached;
      end
      for (int i = 0; i < n; i++)
         if ({1'b0, sh_jobs[i]} < bestv) begin
            bestv = {1'b0, sh_jobs[i]};
            best = i;
         end
      sh_cached = 3'(best);
      sh_cooldown = 2'd2;
      return 3'(best);
   endfunction

   function automatic logic [2:0] most_loaded_core();
      int n;
      int best;
      logic [15:0] bestv;
      n = cores_in_use();
      best = 0;
      bestv = '0;
      for (int i = 0; i < n; i++)
         if (sh_pid[i] == 0 && sh_jobs[i] > bestv) begin
            bestv = sh_jobs[i];
            best = i;
         end
      return (bestv == 0) ? 3'd0 : 3'(best);
   endfunction

   function automatic balance_result_type make_result(logic [1:0] kind, logic [2:0] core,
         logic [2:0] src, logic [15:0] moves, logic [31:0] pid, logic last);
      balance_result_type r;
      r.kind = kind;
      r.core_out = core;
      r.source_core = src;
      r.move_count = moves;
      r.selected_pid = pid;
      r.last = last;
      return r;
   endfunction

   // predict results of one accepted item and update shadow state
   function automatic void predict_balance(logic [1:0] op, logic [31:0] pid, logic tit,
         logic [2:0] core, logic [63:0] now);
      int n;
      logic [2:0] t;
      logic [2:0] src;
      logic [2:0] dst;
      logic [15:0] moves;
      logic [15:0] diff;
      n = cores_in_use();
      case (op)
         OP_SCHEDULE: begin
            if (tit) begin
               for (int i = 1; i < n; i++)
                  if (!sh_touched[i]) begin
                     sh_pid[i] = pid;
                     sh_jobs[i] = CNT_FULL;
                     expected_results.push_back(make_result(KIND_PLACED, 3'(i), 3'd0,
                        16'd0, 32'd0, 1'b1));
                     return;
                  end
            end
            t = least_loaded_core();
            sh_touched[t] = 1'b1;
            if (sh_jobs[t] != CNT_FULL) sh_jobs[t]++;
            expected_results.push_back(make_result(KIND_PLACED, t, 3'd0, 16'd0, 32'd0,
               1'b1));
         end
         OP_UNSCHEDULE: begin
            if (core < n) begin
               if (sh_pid[core] != 0) begin
                  sh_pid[core] = '0;
                  sh_jobs[core] = '0;
               end else begin
                  sh_touched[core] = 1'b1;
                  if (sh_jobs[core] != 0) sh_jobs[core]--;
               end
            end
         end
         OP_SELECT: begin
            if (n > 1 && now > sh_last_pass && now - sh_last_pass > sh_period) begin
               sh_last_pass = now;
               for (int s = 0; s < 2; s++) begin
                  src = most_loaded_core();
                  dst = least_loaded_core();
                  moves = '0;
                  if (sh_jobs[src] > sh_jobs[dst]) begin
                     diff = sh_jobs[src] - sh_jobs[dst];
                     moves = (diff >> 1) + 16'(diff[0]);
                     sh_jobs[src] -= moves;
                     sh_jobs[dst] += moves;
                     sh_touched[dst] = 1'b1;
                  end
                  expected_results.push_back(make_result(KIND_MIGRATION, dst, src, moves,
                     32'd0, 1'b0));
               end
            end
            if (core < n && sh_pid[core] != 0) begin
               expected_results.push_back(make_result(KIND_DEDICATED, core, 3'd0, 16'd0,
                  sh_pid[core], 1'b1));
            end else begin
               if (core < n) sh_touched[core] = 1'b1;
               expected_results.push_back(make_result(KIND_DELEGATE, core, 3'd0, 16'd0,
                  32'd0, 1'b1));
            end
         end
         default: ;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      balance_result_type got;
      balance_result_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         got = make_result(rsp_kind, rsp_core_out, rsp_source_core, rsp_move_count,
            rsp_selected_pid, rsp_last);
         results_seen++;
         if (rsp_kind == KIND_MIGRATION) migrations_seen++;
         if (expected_results.size() == 0) begin
            $display("%0t unexpected item: expected none, actual %p", $time, got);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got != want) begin
               $display("%0t mismatch: expected %p actual %p", $time, want, got);
               errors++;
            end
         end
      end
   end

   // timeout
   always @(posedge clock)
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout, %0d items outstanding", $time, expected_results.size());
         $display("== FAIL ==");
         $finish;
      end

   // send one item, with a random gap before it
   task automatic send_item(logic [1:0] op, logic [31:0] pid, logic tit,
         logic [2:0] core, logic [63:0] now);
      @(posedge clock);
      while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      req_operation <= op;
      req_job_pid <= pid;
      req_titanic <= tit;
      req_core_index <= core;
      req_now_time <= now;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_balance(op, pid, tit, core, now);
      items_sent++;
      start <= 1'b0;
   endtask

   task automatic wait_idle();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_register(logic [0:0] idx, logic [63:0] value);
      wait_idle();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_CORE_COUNT) sh_core_count = value[3:0];
      else sh_period = value;
      @(posedge clock);
   endtask

   // directed corners
   task automatic test_directed();
      logic [63:0] now;
      now = 64'd6000000;
      send_item(OP_SELECT, 32'd0, 1'b0, 3'd0, 64'd0);
      send_item(OP_SCHEDULE, 32'hFFFFFFFF, 1'b1, 3'd0, 64'd0);
      send_item(OP_SCHEDULE, 32'h0, 1'b1, 3'd0, 64'd0);
      send_item(OP_SCHEDULE, 32'h12345678, 1'b0, 3'd7, 64'd0);
      for (int i = 0; i < 5; i++) send_item(OP_SCHEDULE, 32'(i + 1), 1'b0, 3'd0, 64'd0);
      send_item(OP_SELECT, 32'd0, 1'b0, 3'd1, now);
      send_item(OP_SELECT, 32'd0, 1'b0, 3'd2, now);
      send_item(OP_UNSCHEDULE, 32'd0, 1'b0, 3'd1, 64'd0);
      send_item(OP_UNSCHEDULE, 32'd0, 1'b0, 3'd0, 64'd0);
      send_item(OP_UNSCHEDULE, 32'd0, 1'b0, 3'd0, 64'd0);
      send_item(OP_UNSCHEDULE, 32'd0, 1'b0, 3'd0, 64'd0);
      send_item(2'd3, 32'hFFFFFFFF, 1'b1, 3'd7, 64'hFFFFFFFFFFFFFFFF);
      send_item(OP_SELECT, 32'd0, 1'b0, 3'd7, 64'hFFFFFFFFFFFFFFFF);
      send_item(OP_SELECT, 32'd0, 1'b0, 3'd3, 64'h0);
   endtask

   // random traffic under one configuration
   task automatic test_random(int count, logic [3:0] ncfg, logic [63:0] period);
      logic [1:0] op;
      logic [63:0] now;
      write_register(REG_CORE_COUNT, 64'(ncfg));
      write_register(REG_PERIOD, period);
      now = sh_last_pass;
      for (int i = 0; i < count; i++) begin
         op = $urandom_range(99) < 45 ? OP_SCHEDULE :
              ($urandom_range(99) < 50 ? OP_UNSCHEDULE : OP_SELECT);
         if ($urandom_range(49) == 0) op = 2'd3;
         if ($urandom_range(9) == 0) now = {$urandom, $urandom};
         else now = now + $urandom_range(3) * (period > 64'd1000 ? 64'd1000 : period + 1);
         send_item(op, ($urandom_range(3) == 0) ? 32'd0 : $urandom,
            $urandom_range(3) == 0, 3'($urandom), now);
      end
   endtask

   initial begin
      shadow_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_gap_pct = 15;
      test_random(40, 4'd8, 64'd0);
      test_random(25, 4'd1, 64'd10);
      send_gap_pct = 83;
      test_random(25, 4'd0, 64'd2000);
      test_random(25, 4'd15, 64'd1500);
      send_gap_pct = 0;
      test_random(30, 4'd3, 64'hFFFFFFFFFFFFFFFF);
      test_random(20, 4'd8, 64'd500);
      wait_idle();
      $display("sent %0d items, checked %0d results including %0d migrations",
         items_sent, results_seen, migrations_seen);
      $display("core counts 0, 1, 3, 8 and 15 with rebalance periods from zero to all ones");
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
